/* rtl/chtl_pkg.sv */
package chtl_pkg;

  localparam int TABLE_IDS       = 4;
  localparam int NUM_TABLES      = 2 * TABLE_IDS;
  localparam int TBL_W           = $clog2(NUM_TABLES);
  localparam int MAX_SYMBOLS     = 256;
  localparam int MAX_CODE_LENGTH = 16;
  localparam int LEN_W           = 5;
  localparam int LSEL_W          = $clog2(MAX_CODE_LENGTH);
  localparam int CNT_W           = 8;
  localparam int IDX_W           = $clog2(MAX_SYMBOLS + 1);
  localparam int SADDR_W         = $clog2(MAX_SYMBOLS);
  localparam int CODE_W          = 16;
  localparam int SYM_W           = 8;
  localparam int MODE_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int Q_DEPTH         = 2;
  localparam int Q_PTR_W         = $clog2(Q_DEPTH);

  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_COUNT,
    KIND_SYMBOL,
    KIND_LOOKUP
  } kind_e;

  // classified request; status holds the result used for pass-through items
  typedef struct packed {
    kind_e                 kind;
    logic [TBL_W-1:0]      tbl;
    logic [LEN_W-1:0]      len;
    logic                  restart;
    logic [SYM_W-1:0]      value;
    logic [CODE_W-1:0]     code;
    logic [STATUS_W-1:0]   status;
  } item_t;

  function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W:0] x);
    logic [IDX_W-1:0] r;
    if (x > (IDX_W+1)'(MAX_SYMBOLS)) begin
      r = IDX_W'(MAX_SYMBOLS);
    end else begin
      r = x[IDX_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/chtl_front.sv */
module chtl_front import chtl_pkg::*; (
  input  logic                start_i,
  input  logic                full_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [1:0]          table_id_i,
  input  logic                table_class_i,
  input  logic [LEN_W-1:0]    code_length_i,
  input  logic [SYM_W-1:0]    value_i,
  input  logic [CODE_W-1:0]   code_i,
  output logic                push_o,
  output item_t               item_o
);

  logic tab_ok;
  logic len_ok;

  assign push_o = start_i & ~full_i;

  always_comb begin
    tab_ok = (32'(table_id_i) < TABLE_IDS);
    len_ok = (code_length_i >= LEN_W'(1)) && (code_length_i <= LEN_W'(MAX_CODE_LENGTH));

    item_o.tbl     = tab_ok ? {table_id_i, table_class_i} : '0;
    item_o.len     = code_length_i;
    item_o.restart = (code_length_i == LEN_W'(1));
    item_o.code    = code_i;
    item_o.value   = value_i;
    item_o.kind    = KIND_PASS;
    item_o.status  = STATUS_OK;

    case (mode_i)
      MODE_COUNT: begin
        if (tab_ok && len_ok) begin
          item_o.kind = KIND_COUNT;
        end
      end
      MODE_SYMBOL: begin
        item_o.status = STATUS_DROP;
        if (tab_ok) begin
          item_o.kind = KIND_SYMBOL;
        end
      end
      MODE_LOOKUP: begin
        item_o.status = STATUS_MISS;
        item_o.value  = '0;
        if (tab_ok && len_ok) begin
          item_o.kind = KIND_LOOKUP;
        end
      end
      default: begin
        item_o.value = '0;
      end
    endcase
  end

endmodule

/* rtl/chtl_queue.sv */
module chtl_queue import chtl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  item_t                slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q;
  logic [Q_PTR_W-1:0]   rd_ptr_q;
  logic [Q_PTR_W:0]     count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/chtl_back.sv */
module chtl_back import chtl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  item_t                item_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [SYM_W-1:0]     symbol_o,
  output logic [CODE_W-1:0]    assigned_code_o,
  output logic [LEN_W-1:0]     assigned_length_o
);

  localparam int CADDR_W   = TBL_W + LSEL_W;
  localparam int CNT_DEPTH = NUM_TABLES * MAX_CODE_LENGTH;
  localparam int SMADDR_W  = TBL_W + SADDR_W;
  localparam int SYM_DEPTH = NUM_TABLES * MAX_SYMBOLS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SYMRD
  } state_e;

  state_e                state_q;
  item_t                 cur_q;
  logic [LEN_W-1:0]      l_q;
  logic [LEN_W-1:0]      rd_l_q;
  logic                  rd_pend_q;
  logic [CODE_W-1:0]     c_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  cnt_vld_q;
  logic [CNT_DEPTH-1:0]  cnt_valid_q;
  logic [IDX_W-1:0]      loaded_q [NUM_TABLES];

  logic                  result_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [SYM_W-1:0]      symbol_q;
  logic [CODE_W-1:0]     acode_q;
  logic [LEN_W-1:0]      alen_q;

  logic [CNT_W-1:0]      cnt_mem [CNT_DEPTH];
  logic [CNT_W-1:0]      cnt_rd_q;
  logic [SYM_W-1:0]      sym_mem [SYM_DEPTH];
  logic [SYM_W-1:0]      sym_rd_q;

  logic                  cnt_we;
  logic [CADDR_W-1:0]    cnt_waddr;
  logic [CADDR_W-1:0]    cnt_raddr;
  logic [CNT_W-1:0]      cnt_eff;
  logic [IDX_W-1:0]      n;
  logic [IDX_W-1:0]      seg_end;
  logic                  sym_hit;
  logic                  sym_we;
  logic [SMADDR_W-1:0]   sym_waddr;
  logic [SMADDR_W-1:0]   sym_raddr;
  logic [CODE_W-1:0]     c_next;
  logic [CODE_W-1:0]     off;
  logic [IDX_W:0]        lk_idx;
  logic                  lk_hit;
  logic                  at_len;
  logic                  last_l;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    cnt_we    = pop_o && (item_i.kind == KIND_COUNT);
    cnt_waddr = {item_i.tbl, LSEL_W'(item_i.len - 1'b1)};
    cnt_raddr = {cur_q.tbl, LSEL_W'(l_q - 1'b1)};
    cnt_eff   = cnt_vld_q ? cnt_rd_q : '0;
    n         = loaded_q[cur_q.tbl];
    // segment of symbol indices covered by the length just read
    seg_end   = sat_idx({1'b0, idx_q} + (IDX_W+1)'(cnt_eff));
    sym_hit   = (n >= idx_q) && (n < seg_end);
    c_next    = CODE_W'((c_q + CODE_W'(cnt_eff)) << 1);
    off       = cur_q.code - c_q;
    lk_idx    = {1'b0, idx_q} + (IDX_W+1)'(off[CNT_W-1:0]);
    lk_hit    = (off < CODE_W'(cnt_eff)) && (lk_idx < {1'b0, seg_end})
                && (lk_idx < {1'b0, n}) && (lk_idx < (IDX_W+1)'(MAX_SYMBOLS));
    at_len    = (rd_l_q == cur_q.len);
    last_l    = (rd_l_q == LEN_W'(MAX_CODE_LENGTH));
    sym_we    = (state_q == ST_WALK) && rd_pend_q && (cur_q.kind == KIND_SYMBOL) && sym_hit;
    sym_waddr = {cur_q.tbl, n[SADDR_W-1:0]};
    sym_raddr = {cur_q.tbl, lk_idx[SADDR_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= item_i.value;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= cur_q.value;
    end
    sym_rd_q <= sym_mem[sym_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cur_q          <= '0;
      l_q            <= '0;
      rd_l_q         <= '0;
      rd_pend_q      <= 1'b0;
      c_q            <= '0;
      idx_q          <= '0;
      cnt_vld_q      <= 1'b0;
      cnt_valid_q    <= '0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        loaded_q[i] <= '0;
      end
      result_valid_q <= 1'b0;
      status_q       <= '0;
      symbol_q       <= '0;
      acode_q        <= '0;
      alen_q         <= '0;
    end else begin
      result_valid_q <= 1'b0;
      cnt_vld_q      <= cnt_valid_q[cnt_raddr];
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            case (item_i.kind)
              KIND_COUNT: begin
                // a count for length 1 restarts the table
                if (item_i.restart) begin
                  cnt_valid_q[{item_i.tbl, LSEL_W'(0)} +: MAX_CODE_LENGTH] <= '0;
                  loaded_q[item_i.tbl] <= '0;
                end
                cnt_valid_q[cnt_waddr] <= 1'b1;
                result_valid_q <= 1'b1;
                status_q       <= item_i.status;
                symbol_q       <= item_i.value;
                acode_q        <= '0;
                alen_q         <= '0;
              end
              KIND_SYMBOL, KIND_LOOKUP: begin
                cur_q     <= item_i;
                l_q       <= LEN_W'(1);
                rd_pend_q <= 1'b0;
                c_q       <= '0;
                idx_q     <= '0;
                state_q   <= ST_WALK;
              end
              default: begin
                result_valid_q <= 1'b1;
                status_q       <= item_i.status;
                symbol_q       <= item_i.value;
                acode_q        <= '0;
                alen_q         <= '0;
              end
            endcase
          end
        end
        ST_WALK: begin
          l_q       <= l_q + 1'b1;
          rd_l_q    <= l_q;
          rd_pend_q <= 1'b1;
          if (rd_pend_q) begin
            c_q   <= c_next;
            idx_q <= seg_end;
            if (cur_q.kind == KIND_SYMBOL) begin
              if (sym_hit) begin
                loaded_q[cur_q.tbl] <= n + 1'b1;
                result_valid_q <= 1'b1;
                status_q       <= STATUS_OK;
                symbol_q       <= cur_q.value;
                acode_q        <= c_q + CODE_W'(n - idx_q);
                alen_q         <= rd_l_q;
                state_q        <= ST_IDLE;
              end else if (last_l) begin
                result_valid_q <= 1'b1;
                status_q       <= STATUS_DROP;
                symbol_q       <= cur_q.value;
                acode_q        <= '0;
                alen_q         <= '0;
                state_q        <= ST_IDLE;
              end
            end else if (at_len) begin
              if (lk_hit) begin
                state_q <= ST_SYMRD;
              end else begin
                result_valid_q <= 1'b1;
                status_q       <= STATUS_MISS;
                symbol_q       <= '0;
                acode_q        <= '0;
                alen_q         <= '0;
                state_q        <= ST_IDLE;
              end
            end
          end
        end
        ST_SYMRD: begin
          result_valid_q <= 1'b1;
          status_q       <= STATUS_OK;
          symbol_q       <= sym_rd_q;
          acode_q        <= cur_q.code;
          alen_q         <= cur_q.len;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o    = result_valid_q;
  assign status_o          = status_q;
  assign symbol_o          = symbol_q;
  assign assigned_code_o   = acode_q;
  assign assigned_length_o = alen_q;

`ifndef SYNTH
  a_walk_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> (cur_q.kind == KIND_SYMBOL || cur_q.kind == KIND_LOOKUP))
    else $error("walk started for an item that needs no walk");

  a_symrd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SYMRD |=> (result_valid_q && status_q == STATUS_OK))
    else $error("symbol read did not end in a hit result");

  a_lookup_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && rd_pend_q && cur_q.kind == KIND_LOOKUP) |-> rd_l_q <= cur_q.len)
    else $error("lookup walked past its code length");

  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q[cur_q.tbl] <= IDX_W'(MAX_SYMBOLS))
    else $error("symbol count beyond capacity");
`endif

endmodule

/* rtl/canonical_huffman_table_lookup_top.sv */
// Canonical Huffman table store and lookup for eight tables (id x DC/AC class).
// Input: a request is transferred on a rising edge with start high and busy low.
//   mode 0 loads the code count of one length (length 1 restarts the table),
//   mode 1 appends the next symbol, mode 2 looks up a code of a given length.
// Output: every request gives one result, shown for one cycle with
//   result_valid_o high; the receiver has no way to stall it.
// Requests pass a two-entry queue to an execution unit that handles one at a
// time; busy is high while that queue is full.
// Count loads, ignored and malformed requests are answered from the idle state;
//   symbol loads and lookups walk the lengths from 1 upward, a dropped symbol
//   walks all 16 lengths, and a lookup hit adds a read of the symbol memory.
// The length search reads one count per cycle from the count memory; that
// walk sets the throughput.
// Reset empties the queue and clears all counts and symbol fill levels; the
// symbol memory is not cleared, and only entries written since a restart are
// ever read.
module canonical_huffman_table_lookup_top import chtl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [1:0]           table_id_i,
  input  logic                 table_class_i,
  input  logic [LEN_W-1:0]     code_length_i,
  input  logic [SYM_W-1:0]     value_i,
  input  logic [CODE_W-1:0]    code_i,
  output logic                 result_valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [SYM_W-1:0]     symbol_o,
  output logic [CODE_W-1:0]    assigned_code_o,
  output logic [LEN_W-1:0]     assigned_length_o
);

  item_t front_item;
  item_t head_item;
  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;

  assign busy = q_full;

  chtl_front u_front (
    .start_i       (start),
    .full_i        (q_full),
    .mode_i        (mode_i),
    .table_id_i    (table_id_i),
    .table_class_i (table_class_i),
    .code_length_i (code_length_i),
    .value_i       (value_i),
    .code_i        (code_i),
    .push_o        (push),
    .item_o        (front_item)
  );

  chtl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  chtl_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (head_item),
    .empty_i           (q_empty),
    .pop_o             (pop),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .symbol_o          (symbol_o),
    .assigned_code_o   (assigned_code_o),
    .assigned_length_o (assigned_length_o)
  );

endmodule

/* test/tb_canonical_huffman_table_lookup_top.sv */
module tb_canonical_huffman_table_lookup_top;
  timeunit 1ns;
  timeprecision 1ps;

  import chtl_pkg::*;

  localparam int LMAX = MAX_CODE_LENGTH;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // two copies of the table state: one tracks the transfers seen at the block,
  // the other is advanced while the stimulus is planned
  localparam int BANK_DUT = 0;
  localparam int BANK_GEN = 1;
  localparam int ITEM_TARGET = 1350;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [1:0]        tid;
    logic              cls;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  val;
    logic [CODE_W-1:0] code;
  } huff_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SYM_W-1:0]    sym;
    logic [CODE_W-1:0]   acode;
    logic [LEN_W-1:0]    alen;
  } huff_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   mode_i = '0;
  logic [1:0]          table_id_i = '0;
  logic                table_class_i = 1'b0;
  logic [LEN_W-1:0]    code_length_i = '0;
  logic [SYM_W-1:0]    value_i = '0;
  logic [CODE_W-1:0]   code_i = '0;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [SYM_W-1:0]    symbol_o;
  logic [CODE_W-1:0]   assigned_code_o;
  logic [LEN_W-1:0]    assigned_length_o;

  int unsigned      code_counts [2][NUM_TABLES][LMAX+1];
  int unsigned      first_code  [2][NUM_TABLES][LMAX+1];
  int unsigned      first_slot  [2][NUM_TABLES][LMAX+1];
  logic [SYM_W-1:0] sym_mem     [2][NUM_TABLES][MAX_SYMBOLS];
  int unsigned      sym_fill    [2][NUM_TABLES];

  huff_req_t pending_reqs[$];
  huff_res_t expected_results[$];
  int        n_items = 0;
  int        err_cnt = 0;
  int        gap_left = 0;
  int        burst_left = 1;
  bit        took = 1'b0;

  canonical_huffman_table_lookup_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .mode_i            (mode_i),
    .table_id_i        (table_id_i),
    .table_class_i     (table_class_i),
    .code_length_i     (code_length_i),
    .value_i           (value_i),
    .code_i            (code_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .symbol_o          (symbol_o),
    .assigned_code_o   (assigned_code_o),
    .assigned_length_o (assigned_length_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned clamp_slot(input int unsigned x);
    return (x > MAX_SYMBOLS) ? MAX_SYMBOLS : x;
  endfunction

  // canonical first code and first symbol slot of every length
  function automatic void rebuild_starts(input int b, input int t);
    int unsigned c;
    int unsigned idx;
    c = 0;
    idx = 0;
    for (int l = 1; l <= LMAX; l++) begin
      first_code[b][t][l] = c & 32'hFFFF;
      first_slot[b][t][l] = idx;
      c = ((c + code_counts[b][t][l]) << 1) & 32'hFFFF;
      idx = clamp_slot(idx + code_counts[b][t][l]);
    end
  endfunction

  function automatic huff_res_t decode_step(input int b, input huff_req_t r);
    huff_res_t   e;
    bit          tab_ok;
    bit          len_ok;
    bit          found;
    int unsigned t;
    int unsigned n;
    int unsigned s;
    int unsigned lim;
    int unsigned off;
    int unsigned idx;
    e = '0;
    found = 1'b0;
    tab_ok = r.tid < TABLE_IDS;
    len_ok = r.len >= 1 && r.len <= LMAX;
    t = tab_ok ? r.tid * 2 + r.cls : 0;
    case (r.mode)
      MODE_COUNT: begin
        e.sym = r.val;
        if (tab_ok && len_ok) begin
          if (r.len == 1) begin
            for (int l = 0; l <= LMAX; l++) code_counts[b][t][l] = 0;
            sym_fill[b][t] = 0;
          end
          code_counts[b][t][r.len] = r.val;
          rebuild_starts(b, t);
        end
      end
      MODE_SYMBOL: begin
        e.sym = r.val;
        e.status = STATUS_DROP;
        if (tab_ok) begin
          n = sym_fill[b][t];
          for (int l = 1; l <= LMAX; l++) begin
            if (!found) begin
              s = first_slot[b][t][l];
              lim = clamp_slot(s + code_counts[b][t][l]);
              if (n >= s && n < lim) begin
                found = 1'b1;
                sym_mem[b][t][n] = r.val;
                sym_fill[b][t] = n + 1;
                e.acode = CODE_W'(first_code[b][t][l] + n - s);
                e.alen = LEN_W'(l);
                e.status = STATUS_OK;
              end
            end
          end
        end
      end
      MODE_LOOKUP: begin
        e.status = STATUS_MISS;
        if (tab_ok && len_ok) begin
          off = (32'(r.code) - first_code[b][t][r.len]) & 32'hFFFF;
          if (off < code_counts[b][t][r.len]) begin
            idx = first_slot[b][t][r.len] + off;
            lim = clamp_slot(first_slot[b][t][r.len] + code_counts[b][t][r.len]);
            if (idx < lim && idx < sym_fill[b][t] && idx < MAX_SYMBOLS) begin
              e.sym = sym_mem[b][t][idx];
              e.acode = r.code;
              e.alen = r.len;
              e.status = STATUS_OK;
            end
          end
        end
      end
      default: e = '0;
    endcase
    return e;
  endfunction

  task automatic push(input int m, input int tid, input int cls, input int len,
                      input int val, input int code);
    huff_req_t r;
    r.mode = MODE_W'(m);
    r.tid = 2'(tid);
    r.cls = 1'(cls);
    r.len = LEN_W'(len);
    r.val = SYM_W'(val);
    r.code = CODE_W'(code);
    pending_reqs.push_back(r);
    void'(decode_step(BANK_GEN, r));
    if (r.mode != MODE_UNUSED) n_items++;
  endtask

  // count loads in order 1..16 that never overflow the code space
  task automatic load_wellformed(input int tid, input int cls, input int max_per_len);
    int unsigned room;
    int unsigned lim;
    int unsigned n;
    room = 1;
    for (int l = 1; l <= LMAX; l++) begin
      room = room * 2;
      n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, max_per_len) : 0;
      lim = (l < LMAX) ? room - 1 : room;
      if (n > lim) n = lim;
      if (n > 255) n = 255;
      room -= n;
      push(MODE_COUNT, tid, cls, l, n, $urandom_range(0, 65535));
    end
  endtask

  task automatic load_symbols(input int tid, input int cls, input int n);
    repeat (n) push(MODE_SYMBOL, tid, cls, $urandom_range(0, 31), $urandom_range(0, 255),
                    $urandom_range(0, 65535));
  endtask

  function automatic int table_total(input int tid, input int cls);
    int unsigned sum;
    sum = 0;
    for (int l = 1; l <= LMAX; l++) sum += code_counts[BANK_GEN][tid*2+cls][l];
    return clamp_slot(sum);
  endfunction

  // mostly codes that exist in the planned table, the rest arbitrary
  task automatic lookups(input int tid, input int cls, input int k);
    int t;
    int l;
    int pick;
    t = tid * 2 + cls;
    repeat (k) begin
      l = 0;
      if ($urandom_range(0, 4) != 0) begin
        for (int tries = 0; tries < 16 && l == 0; tries++) begin
          pick = $urandom_range(1, LMAX);
          if (code_counts[BANK_GEN][t][pick] != 0) l = pick;
        end
      end
      if (l != 0) begin
        push(MODE_LOOKUP, tid, cls, l, $urandom_range(0, 255),
             first_code[BANK_GEN][t][l] +
             $urandom_range(0, code_counts[BANK_GEN][t][l] - 1));
      end else begin
        push(MODE_LOOKUP, tid, cls,
             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, LMAX),
             $urandom_range(0, 255), $urandom_range(0, 65535));
      end
    end
  endtask

  initial begin
    int tid;
    int cls;
    int pick;
    int tot;

    // empty tables, bad lengths and the unused mode
    push(MODE_UNUSED, 1, 1, 5, 8'hA5, 16'h5A5A);
    push(MODE_COUNT, 0, 0, 0, 3, 0);
    push(MODE_COUNT, 0, 0, 17, 3, 0);
    push(MODE_LOOKUP, 0, 0, 1, 0, 0);
    push(MODE_LOOKUP, 0, 0, 0, 0, 0);
    push(MODE_LOOKUP, 0, 0, 31, 0, 16'hFFFF);
    push(MODE_SYMBOL, 3, 1, 0, 8'h7E, 0);
    // small table with codes of length 2, 3 and 16; sixth symbol overflows
    push(MODE_COUNT, 0, 0, 1, 0, 0);
    push(MODE_COUNT, 0, 0, 2, 1, 0);
    push(MODE_COUNT, 0, 0, 3, 2, 0);
    push(MODE_COUNT, 0, 0, 16, 2, 0);
    push(MODE_SYMBOL, 0, 0, 0, 8'h00, 0);
    push(MODE_SYMBOL, 0, 0, 0, 8'hFF, 0);
    push(MODE_SYMBOL, 0, 0, 0, 8'h55, 0);
    push(MODE_SYMBOL, 0, 0, 0, 8'hAA, 0);
    push(MODE_SYMBOL, 0, 0, 0, 8'h01, 0);
    push(MODE_SYMBOL, 0, 0, 0, 8'h80, 0);
    push(MODE_LOOKUP, 0, 0, 2, 0, 16'h0000);
    push(MODE_LOOKUP, 0, 0, 3, 0, 16'h0003);
    push(MODE_LOOKUP, 0, 0, 16, 0, 16'h8001);
    push(MODE_LOOKUP, 0, 0, 16, 0, 16'hFFFF);
    push(MODE_LOOKUP, 0, 0, 3, 0, 16'h0001);

    // one table past MAX_SYMBOLS so slot saturation and capacity drops show up
    tid = $urandom_range(0, 3);
    cls = $urandom_range(0, 1);
    for (int l = 1; l <= LMAX; l++) begin
      push(MODE_COUNT, tid, cls, l, (l == 9) ? 255 : (l == 10) ? 200 : 0, 0);
    end
    load_symbols(tid, cls, MAX_SYMBOLS + 2);
    lookups(tid, cls, 24);

    while (n_items < ITEM_TARGET) begin
      tid = $urandom_range(0, 3);
      cls = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        load_wellformed(tid, cls, (pick < 4) ? 24 : 3);
        tot = table_total(tid, cls);
        load_symbols(tid, cls, ($urandom_range(0, 3) == 0) ? $urandom_range(0, tot)
                                                           : tot + $urandom_range(0, 2));
        lookups(tid, cls, $urandom_range(4, 16));
      end else if (pick < 18) begin
        // arbitrary counts, first codes wrap; sometimes no restart
        for (int l = $urandom_range(1, 2); l <= LMAX; l++) begin
          if ($urandom_range(0, 1) == 0) begin
            push(MODE_COUNT, tid, cls, l, $urandom_range(0, 255), $urandom_range(0, 65535));
          end
        end
        load_symbols(tid, cls, $urandom_range(1, 6));
        lookups(tid, cls, $urandom_range(2, 8));
      end else if (pick < 70) begin
        lookups(tid, cls, $urandom_range(1, 8));
      end else if (pick < 80) begin
        load_symbols(tid, cls, $urandom_range(1, 4));
      end else begin
        push($urandom_range(0, 3), tid, cls, $urandom_range(0, 31), $urandom_range(0, 255),
             $urandom_range(0, 65535));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: a new request goes out once the previous one has transferred
  always @(negedge clk_i) begin
    huff_req_t r;
    if (rst_ni && !(start && !took)) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        start <= 1'b1;
        mode_i <= r.mode;
        table_id_i <= r.tid;
        table_class_i <= r.cls;
        code_length_i <= r.len;
        value_i <= r.val;
        code_i <= r.code;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the strobed result, then record any request transfer
  always @(posedge clk_i) begin
    huff_res_t got;
    huff_res_t want;
    huff_req_t acc;
    took <= rst_ni && start && !busy;
    if (rst_ni && result_valid_o) begin
      got = {status_o, symbol_o, assigned_code_o, assigned_length_o};
      if (expected_results.size() == 0) begin
        $error("result with none pending: status %0d symbol %0h", status_o, symbol_o);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_cnt++;
        end
        if (got.sym !== want.sym) begin
          $error("symbol: expected %0h, got %0h", want.sym, got.sym);
          err_cnt++;
        end
        if (got.acode !== want.acode) begin
          $error("assigned_code: expected %0h, got %0h", want.acode, got.acode);
          err_cnt++;
        end
        if (got.alen !== want.alen) begin
          $error("assigned_length: expected %0d, got %0d", want.alen, got.alen);
          err_cnt++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      acc = {mode_i, table_id_i, table_class_i, code_length_i, value_i, code_i};
      expected_results.push_back(decode_step(BANK_DUT, acc));
    end
  end

  initial begin
    wait (rst_ni);
    while (pending_reqs.size() != 0 || start) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
